[rtl/core/lgre_pkg.sv]
// Shared types, constants and the Life rule for the Life row engine.
// No dependencies; every other file of the block uses it.
`default_nettype none

package lgre_pkg;

  localparam int ROW_W       = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int WIDTH_W     = 7;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;

  // neighbor counts of the B3/S23 rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // result queue
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;
  localparam logic [Q_CNT_W-1:0] Q_DEPTH = 3'd4;

  typedef struct packed {
    logic [ROW_W-1:0] cells;
    logic             last;
  } res_t;

  // bits one column shows its neighbors
  typedef struct packed {
    logic upper;
    logic middle;
    logic fresh;
  } nbr_t;

  function automatic logic next_state(input logic alive, input logic [7:0] nb);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, nb[i]};
    end
    return (n == BIRTH_COUNT) || (alive && (n == SURVIVE_COUNT));
  endfunction

endpackage

`default_nettype wire

[rtl/core/lgre_ifs.sv]
// Handshake interfaces of the Life row engine: rows, results, configuration.
// Depends on lgre_pkg.
`default_nettype none

interface lgre_row_if;
  logic                      valid;
  logic                      ready;
  logic [lgre_pkg::ROW_W-1:0] row_cells;
  logic                      last_row;
  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink (input valid, input row_cells, input last_row, output ready);
endinterface

interface lgre_res_if;
  logic                      valid;
  logic                      ready;
  logic [lgre_pkg::ROW_W-1:0] next_row_cells;
  logic                      last_of_grid;
  modport source (output valid, output next_row_cells, output last_of_grid, input ready);
  modport sink (input valid, input next_row_cells, input last_of_grid, output ready);
endinterface

interface lgre_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lgre_pkg::WIDTH_W-1:0] active_width;
  modport source (output valid, output active_width, input ready);
  modport sink (input valid, input active_width, output ready);
endinterface

`default_nettype wire

[rtl/core/lgre_cell.sv]
// One column of the Life row engine: holds the column's bits of the two
// previous rows and applies the B3/S23 rule. Depends on lgre_pkg.
`default_nettype none

module lgre_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          seen,
  input  wire logic          last,
  input  wire logic          enable,
  input  wire logic          cell_in,
  input  wire lgre_pkg::nbr_t left,
  input  wire lgre_pkg::nbr_t right,
  output lgre_pkg::nbr_t     own,
  output logic               res_held,
  output logic               res_last
);

  logic upper;
  logic middle;
  logic fresh;
  logic top_l, top_c, top_r;

  assign fresh      = cell_in & enable;
  assign own.upper  = upper;
  assign own.middle = middle;
  assign own.fresh  = fresh;

  // held row, with the new row below it
  assign res_held = enable & lgre_pkg::next_state(middle,
      {left.upper, upper, right.upper, left.middle, right.middle,
       left.fresh, fresh, right.fresh});

  // new row as the bottom row: held row above (if any), dead row below
  assign top_l = seen & left.middle;
  assign top_c = seen & middle;
  assign top_r = seen & right.middle;
  assign res_last = enable & lgre_pkg::next_state(fresh,
      {top_l, top_c, top_r, left.fresh, right.fresh, 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      upper  <= 1'b0;
      middle <= 1'b0;
    end else if (step) begin
      if (last) begin
        upper  <= 1'b0;
        middle <= 1'b0;
      end else begin
        upper  <= top_c;
        middle <= fresh;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/lgre_out_queue.sv]
// Four-word result queue of the Life row engine; takes up to two words a
// cycle and drives the result channel from a register. Depends on lgre_pkg, lgre_ifs.
`default_nettype none

module lgre_out_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_a,
  input  wire logic           push_b,
  input  wire lgre_pkg::res_t word_a,
  input  wire lgre_pkg::res_t word_b,
  output logic                room,
  lgre_res_if.source          results
);

  lgre_pkg::res_t mem [0:(1 << lgre_pkg::Q_PTR_W)-1];
  logic [lgre_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [lgre_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [lgre_pkg::Q_CNT_W-1:0] count;
  logic [lgre_pkg::Q_CNT_W-1:0] count_next;
  logic [lgre_pkg::Q_PTR_W-1:0] wr_ptr_b;
  logic                         pop;

  assign pop      = results.valid & results.ready;
  assign wr_ptr_b = wr_ptr + {{(lgre_pkg::Q_PTR_W-1){1'b0}}, 1'b1};
  assign count_next = count + {{(lgre_pkg::Q_CNT_W-1){1'b0}}, push_a}
                            + {{(lgre_pkg::Q_CNT_W-1){1'b0}}, push_b}
                            - {{(lgre_pkg::Q_CNT_W-1){1'b0}}, pop};

  // room for two more words regardless of the receiver
  assign room = (count <= (lgre_pkg::Q_DEPTH - 3'd2));

  assign results.valid          = (count != '0);
  assign results.next_row_cells = mem[rd_ptr].cells;
  assign results.last_of_grid   = mem[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= word_a;
    end
    if (push_b) begin
      mem[wr_ptr_b] <= word_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push_b) begin
        wr_ptr <= wr_ptr + lgre_pkg::Q_PTR_W'(2);
      end else if (push_a) begin
        wr_ptr <= wr_ptr_b;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + {{(lgre_pkg::Q_PTR_W-1){1'b0}}, 1'b1};
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lgre_pkg::Q_DEPTH)
    else $error("result queue count above depth");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push_b |-> push_a)
    else $error("second word pushed without first");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_a || push_b) |-> room)
    else $error("push into full result queue");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (count == 3'd1 && pop && !push_a) |=> !results.valid)
    else $error("queue still valid after last word taken");
`endif

endmodule

`default_nettype wire

[rtl/core/life_generation_row_engine_top.sv]
// Life row engine top level: a chain of column cells plus the result queue.
// Depends on lgre_pkg, lgre_ifs, lgre_cell, lgre_out_queue.
//
// Use: the grid streams in on rows, one word per row, top to bottom, with
// last_row set on the bottom row. Each word yields the next-generation row
// of the row above it (none for the first row of a grid); the bottom-row
// word also yields its own result, so it makes two words on results, the
// second with last_of_grid set. A one-row grid gives one word.
// A result word is in the queue the cycle after the row that completes it
// is taken. Throughput: one row per cycle while the queue has room; every
// column is evaluated in parallel by its cell, so the rate is set by the
// result queue only, which takes two words in one cycle. Stall: rows.ready
// drops while the four-word queue has fewer than two free entries; a
// stalled receiver holds its word in the queue. cfg sets active_width
// (columns at or above it are dead); it is always ready. The user must
// write it only while no row is offered and no word is pending; the block
// does not enforce this. Reset: no row held, queue empty, active_width = 64.
`default_nettype none

module life_generation_row_engine_top #(
  parameter int MAX_COLUMNS = lgre_pkg::MAX_COLUMNS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  lgre_row_if.sink    rows,
  lgre_res_if.source  results,
  lgre_cfg_if.sink    cfg
);

  logic [lgre_pkg::WIDTH_W-1:0] active_width;
  logic                         rows_seen;
  logic                         accept;
  logic                         room;
  logic                         push_a;
  logic                         push_b;
  logic [MAX_COLUMNS-1:0]       held_bits;
  logic [MAX_COLUMNS-1:0]       last_bits;
  lgre_pkg::nbr_t               nbr [0:MAX_COLUMNS-1];
  lgre_pkg::res_t               word_held;
  lgre_pkg::res_t               word_last;
  lgre_pkg::res_t               word_a;

  assign cfg.ready  = 1'b1;
  assign rows.ready = room;
  assign accept     = rows.valid & room;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width <= lgre_pkg::WIDTH_RESET;
    end else if (cfg.valid) begin
      active_width <= cfg.active_width;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_seen <= 1'b0;
    end else if (accept) begin
      rows_seen <= !rows.last_row;
    end
  end

  for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_col
    lgre_pkg::nbr_t left;
    lgre_pkg::nbr_t right;
    logic           enable;

    assign enable = (lgre_pkg::WIDTH_W'(k) < active_width);

    if (k == 0) begin : g_l_edge
      assign left = '0;
    end else begin : g_l_mid
      assign left = nbr[k-1];
    end
    if (k == MAX_COLUMNS - 1) begin : g_r_edge
      assign right = '0;
    end else begin : g_r_mid
      assign right = nbr[k+1];
    end

    lgre_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (accept),
      .seen     (rows_seen),
      .last     (rows.last_row),
      .enable   (enable),
      .cell_in  (rows.row_cells[k]),
      .left     (left),
      .right    (right),
      .own      (nbr[k]),
      .res_held (held_bits[k]),
      .res_last (last_bits[k])
    );
  end

  assign word_held.cells = lgre_pkg::ROW_W'(held_bits);
  assign word_held.last  = 1'b0;
  assign word_last.cells = lgre_pkg::ROW_W'(last_bits);
  assign word_last.last  = 1'b1;

  // held row's result goes first, the bottom row's result after it
  assign push_a = accept & (rows_seen | rows.last_row);
  assign push_b = accept & rows_seen & rows.last_row;
  assign word_a = rows_seen ? word_held : word_last;

  lgre_out_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_a  (push_a),
    .push_b  (push_b),
    .word_a  (word_a),
    .word_b  (word_last),
    .room    (room),
    .results (results)
  );

`ifndef NO_ASSERTIONS
  a_grid_end: assert property (@(posedge clk) disable iff (rst)
    (accept && rows.last_row) |=> !rows_seen)
    else $error("row still held after bottom row");
  a_row_held: assert property (@(posedge clk) disable iff (rst)
    (accept && !rows.last_row) |=> rows_seen)
    else $error("row not held after accept");
  a_first_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && !rows_seen && !rows.last_row) |-> !push_a)
    else $error("result word pushed for first row");
`endif

endmodule

`default_nettype wire

[tb/sv/lgre_generation_checker.sv]
// Scoreboard for the Life row engine: watches rows, results and cfg words,
// predicts each next-generation row and compares it with what comes out.
// Depends on lgre_pkg and lgre_ifs.
module lgre_generation_checker
  import lgre_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lgre_row_if  rows,
  lgre_res_if  results,
  lgre_cfg_if  cfg,
  output int   mismatches,
  output int   pending
);

  logic [WIDTH_W-1:0] width_now;
  logic [ROW_W-1:0]   row_above;
  logic [ROW_W-1:0]   row_held;
  logic               holding;
  res_t               expected_rows[$];

  function automatic logic [ROW_W-1:0] column_mask(input logic [WIDTH_W-1:0] w);
    int cols;
    cols = (w > MAX_COLUMNS) ? MAX_COLUMNS : int'(w);
    if (cols >= ROW_W) return '1;
    return (64'd1 << cols) - 64'd1;
  endfunction

  // B3/S23 over one row, cells outside the grid are dead
  function automatic logic [ROW_W-1:0] next_generation(input logic [ROW_W-1:0] above,
                                                       input logic [ROW_W-1:0] here,
                                                       input logic [ROW_W-1:0] below,
                                                       input logic [ROW_W-1:0] keep);
    logic [ROW_W-1:0] nxt;
    int n;
    int col;
    nxt = '0;
    for (int k = 0; k < MAX_COLUMNS; k++) begin
      n = 0;
      for (int dk = -1; dk <= 1; dk++) begin
        col = k + dk;
        if (col >= 0 && col < MAX_COLUMNS) begin
          n += int'(above[col]) + int'(below[col]);
          if (dk != 0) n += int'(here[col]);
        end
      end
      nxt[k] = (n == 3) || (here[k] && n == 2);
    end
    return nxt & keep;
  endfunction

  always @(posedge clk) begin
    logic [ROW_W-1:0] keep;
    logic [ROW_W-1:0] row;
    res_t want;
    if (rst) begin
      width_now = WIDTH_RESET;
      row_above = '0;
      row_held = '0;
      holding = 1'b0;
      expected_rows.delete();
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) width_now = cfg.active_width;

      if (rows.valid && rows.ready) begin
        keep = column_mask(width_now);
        row = rows.row_cells & keep;
        if (holding) begin
          want.cells = next_generation(row_above, row_held, row, keep);
          want.last = 1'b0;
          expected_rows.push_back(want);
          row_above = row_held;
        end else begin
          row_above = '0;
        end
        row_held = row;
        holding = 1'b1;
        // bottom row: flush it against a dead row below and start over
        if (rows.last_row) begin
          want.cells = next_generation(row_above, row_held, '0, keep);
          want.last = 1'b1;
          expected_rows.push_back(want);
          row_above = '0;
          row_held = '0;
          holding = 1'b0;
        end
      end

      if (results.valid && results.ready) begin
        if (expected_rows.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, cells %h last %b", $time,
                   results.next_row_cells, results.last_of_grid);
        end else begin
          want = expected_rows.pop_front();
          if (results.next_row_cells !== want.cells) begin
            mismatches++;
            $display("%0t: next_row_cells expected %h got %h", $time, want.cells,
                     results.next_row_cells);
          end
          if (results.last_of_grid !== want.last) begin
            mismatches++;
            $display("%0t: last_of_grid expected %b got %b", $time, want.last,
                     results.last_of_grid);
          end
        end
      end
    end
    pending <= expected_rows.size();
  end

endmodule

[tb/sv/life_generation_row_engine_top_test.sv]
// Stimulus and verdict for the Life row engine: streams directed and random
// grids under random stalls, retunes the width between and within grids.
// Depends on lgre_pkg, lgre_ifs, the engine and lgre_generation_checker.
module life_generation_row_engine_top_test;
  import lgre_pkg::*;

  logic clk;
  logic rst;
  bit   pauses_on = 1'b1;
  int   mismatch_count;
  int   pending_rows;

  lgre_row_if rows_ch ();
  lgre_res_if res_ch ();
  lgre_cfg_if cfg_ch ();

  life_generation_row_engine_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .rows    (rows_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  lgre_generation_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .rows       (rows_ch),
    .results    (res_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatch_count),
    .pending    (pending_rows)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // valid stays high after a word is taken; the next call keeps or drops it
  task automatic send_row(input logic [ROW_W-1:0] cells, input logic last);
    int gap;
    gap = pauses_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      rows_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rows_ch.valid <= 1'b1;
    rows_ch.row_cells <= cells;
    rows_ch.last_row <= last;
    do @(posedge clk); while (!rows_ch.ready);
  endtask

  // hold rows until every predicted result has come out
  task automatic drain();
    rows_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_rows != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_width(input logic [WIDTH_W-1:0] w);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.active_width <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return a & b & {$urandom, $urandom};
      1: return a | b;
      2: return $urandom_range(0, 1) ? '1 : '0;
      3: return 64'(a[2:0]) << $urandom_range(0, 63);
      default: return a;
    endcase
  endfunction

  function automatic logic [WIDTH_W-1:0] random_width();
    case ($urandom_range(0, 9))
      0: return 7'd1;
      1: return 7'd64;
      2: return 7'd0;
      3: return 7'($urandom_range(65, 127));
      4: return 7'd63;
      5: return 7'($urandom_range(2, 4));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = pauses_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  initial begin
    int sent;
    int height;
    rst <= 1'b1;
    rows_ch.valid <= 1'b0;
    rows_ch.row_cells <= '0;
    rows_ch.last_row <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.active_width <= WIDTH_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-row grid: interior cells keep two neighbors, the ends die
    set_width(7'd64);
    send_row('1, 1'b1);
    // blinker flips to vertical
    send_row('0, 1'b0);
    send_row(64'h7 << 30, 1'b0);
    send_row('0, 1'b1);
    // full board
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    // still-life blocks against both side borders
    send_row(64'hC000_0000_0000_0003, 1'b0);
    send_row(64'hC000_0000_0000_0003, 1'b1);
    // narrow the width while a row is held
    send_row('1, 1'b0);
    set_width(7'd8);
    send_row('1, 1'b1);
    // single column
    set_width(7'd1);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    // zero width kills everything
    set_width(7'd0);
    send_row('1, 1'b0);
    send_row(64'hAAAA_5555_AAAA_5555, 1'b1);
    // width beyond the column count clamps
    set_width(7'd127);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'hC000_0000_0000_0003, 1'b1);

    sent = 0;
    while (sent < 450) begin
      if ($urandom_range(0, 7) == 0) set_width(random_width());
      else if ($urandom_range(0, 9) == 0) drain();
      if ($urandom_range(0, 5) == 0) pauses_on = !pauses_on;
      height = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 12);
      for (int r = 0; r < height; r++) send_row(random_row(), r == height - 1);
      sent += height;
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_rows == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
